/* hdl/cvw_pkg.sv */
// Shared types and constants of the wraparound 2-D convolution unit.
`timescale 1ns / 1ps
`default_nettype none

package cvw_pkg;

	// Payload widths.
	localparam int POS_W   = 8;
	localparam int PIX_W   = 8;
	localparam int COEF_W  = 16;
	localparam int RESP_W  = 32;
	localparam int CRD_W   = 9;
	localparam int KCFG_W  = 3;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_ROWS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_COLS = 2'd3;

	localparam logic [CRD_W-1:0]  IMAGE_SIZE_RST  = 9'd256;
	localparam logic [KCFG_W-1:0] KERNEL_SIZE_RST = 3'd3;

	// The remainder unit retires one dividend bit per cycle.
	localparam int                DIV_CNT_W = 3;
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = 3'(POS_W - 1);

	typedef enum logic [1:0] {
		OP_LOAD_COEF  = 2'd0,
		OP_LOAD_PIXEL = 2'd1,
		OP_COMPUTE    = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_OFFSET,
		ST_WALK,
		ST_DRAIN,
		ST_HOLD
	} cvw_state_t;

	// Tag that travels alongside each kernel tap through the datapath.
	typedef struct packed {
		logic valid;
		logic last;
	} cvw_tap_t;

endpackage

`default_nettype wire

/* hdl/cvw_channels.sv */
// Valid/ready channel interfaces for the request and result streams.
`timescale 1ns / 1ps
`default_nettype none

interface cvw_item_if;
	import cvw_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [1:0]               opcode;
	logic [POS_W-1:0]         row;
	logic [POS_W-1:0]         col;
	logic [PIX_W-1:0]         pixel;
	logic signed [COEF_W-1:0] coefficient;

	modport source (output valid, opcode, row, col, pixel, coefficient, input ready);
	modport sink   (input valid, opcode, row, col, pixel, coefficient, output ready);
endinterface

interface cvw_result_if;
	import cvw_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [POS_W-1:0]         out_row;
	logic [POS_W-1:0]         out_col;
	logic signed [RESP_W-1:0] response;

	modport source (output valid, out_row, out_col, response, input ready);
	modport sink   (input valid, out_row, out_col, response, output ready);
endinterface

`default_nettype wire

/* hdl/cvw_mac.sv */
// Multiply, round half away from zero and accumulate datapath for kernel taps.
`timescale 1ns / 1ps
`default_nettype none

module cvw_mac (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             clear,
	input  cvw_pkg::cvw_tap_t                tap,
	input  logic [cvw_pkg::PIX_W-1:0]        pixel,
	input  logic signed [cvw_pkg::COEF_W-1:0] coefficient,
	output logic signed [cvw_pkg::RESP_W-1:0] acc,
	output logic                             done
);
	import cvw_pkg::*;

	localparam int PROD_W = PIX_W + 1 + COEF_W;

	cvw_tap_t                 tap_s2;
	cvw_tap_t                 tap_s3;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [RESP_W-1:0] rnd_s3;
	logic signed [RESP_W-1:0] acc_q;
	logic                     done_q;

	logic [PROD_W-1:0] mag;
	logic [PROD_W-1:0] mag_rnd;
	logic [RESP_W-1:0] q_ext;
	logic [RESP_W-1:0] rnd;

	// The magnitude is rounded so that halves move away from zero for either sign.
	always_comb begin
		mag     = prod_s2[PROD_W-1] ? PROD_W'(-prod_s2) : PROD_W'(prod_s2);
		mag_rnd = mag + PROD_W'(128);
		q_ext   = RESP_W'(mag_rnd[PROD_W-1:8]);
		rnd     = prod_s2[PROD_W-1] ? (~q_ext + RESP_W'(1)) : q_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_s2 <= '0;
			tap_s3 <= '0;
			done_q <= 1'b0;
		end else begin
			tap_s2 <= tap;
			tap_s3 <= tap_s2;
			done_q <= tap_s3.valid & tap_s3.last;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= $signed({1'b0, pixel}) * coefficient;
		rnd_s3  <= $signed(rnd);
		if (clear) begin
			acc_q <= '0;
		end else if (tap_s3.valid) begin
			acc_q <= acc_q + rnd_s3;
		end
	end

	assign acc  = acc_q;
	assign done = done_q;

endmodule

`default_nettype wire

/* hdl/convolution_2d_wraparound_unit.sv */
// Top level of the 2-D convolution unit with circular image boundary.
`timescale 1ns / 1ps
`default_nettype none

// The unit keeps an 8-bit image and a signed Q8.8 kernel in two on-chip
// memories. Load items (coefficient or pixel) are written in the cycle they
// are accepted and produce no result. A compute item centers the kernel on
// the requested pixel, with neighbor coordinates wrapping around the image
// edges, and returns one transaction with the echoed row and column and the
// 32-bit wrapping sum of the rounded products. A compute item first reduces
// its row and column modulo the image size in a bit-serial remainder unit,
// then steps back half a kernel with wraparound, then reads one pixel and
// one coefficient per cycle through the single read port of each memory,
// then drains the memory read register and the three-stage multiply, round
// and accumulate pipeline, and finally moves the result into the output
// register once that register is free. No new item is accepted while a
// compute item is in progress. The next item is accepted once the result
// sits in the output register, even if the sink has not taken it yet.
// Image and kernel sizes are clamped on use: zero counts as one, oversized
// values as the maximum, and an even kernel size as the odd size below it.
// Configuration must only be written while the unit is idle. Reading a
// memory entry that was never written returns an undefined value.

module convolution_2d_wraparound_unit #(
	parameter int MAX_ROWS   = 256,
	parameter int MAX_COLS   = 256,
	parameter int MAX_KERNEL = 7
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [cvw_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cvw_pkg::CFG_DATA_W-1:0]      cfg_data,
	cvw_item_if.sink                            item,
	cvw_result_if.source                        result
);
	import cvw_pkg::*;

	localparam int PIX_DEPTH = MAX_ROWS * MAX_COLS;
	localparam int PA_W      = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;
	localparam int KER_DEPTH = MAX_KERNEL * MAX_KERNEL;
	localparam int KA_W      = (KER_DEPTH > 1) ? $clog2(KER_DEPTH) : 1;
	localparam int KI_W      = $clog2(MAX_KERNEL + 1);
	localparam int KTOP      = (MAX_KERNEL % 2 == 1) ? MAX_KERNEL : MAX_KERNEL - 1;
	localparam int MUL_W     = CRD_W + 14;
	localparam int CMP_W     = 14;

	// Configuration registers.
	logic [CRD_W-1:0]  image_rows_q;
	logic [CRD_W-1:0]  image_cols_q;
	logic [KCFG_W-1:0] kernel_rows_q;
	logic [KCFG_W-1:0] kernel_cols_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_rows_q  <= IMAGE_SIZE_RST;
			image_cols_q  <= IMAGE_SIZE_RST;
			kernel_rows_q <= KERNEL_SIZE_RST;
			kernel_cols_q <= KERNEL_SIZE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IMAGE_ROWS:  image_rows_q  <= cfg_data;
				CFG_IMAGE_COLS:  image_cols_q  <= cfg_data;
				CFG_KERNEL_ROWS: kernel_rows_q <= cfg_data[KCFG_W-1:0];
				CFG_KERNEL_COLS: kernel_cols_q <= cfg_data[KCFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sizes as they are used: zero becomes one, oversized values are capped,
	// and an even kernel size drops to the odd size below it.
	function automatic logic [CRD_W-1:0] clamp_image(input logic [CRD_W-1:0] v,
	                                                 input int maxv);
		logic [CRD_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = CRD_W'(1);
		end else if (CMP_W'(v) > CMP_W'(maxv)) begin
			r = CRD_W'(maxv);
		end
		return r;
	endfunction

	function automatic logic [KI_W-1:0] clamp_kernel(input logic [KCFG_W-1:0] v);
		logic [KI_W-1:0] r;
		if (v == '0) begin
			r = KI_W'(1);
		end else if (5'(v) > 5'(KTOP)) begin
			r = KI_W'(KTOP);
		end else if (!v[0]) begin
			r = KI_W'(v - KCFG_W'(1));
		end else begin
			r = KI_W'(v);
		end
		return r;
	endfunction

	logic [CRD_W-1:0] nr;
	logic [CRD_W-1:0] nc;
	logic [KI_W-1:0]  kr;
	logic [KI_W-1:0]  kc;
	logic [KI_W-1:0]  hr;
	logic [KI_W-1:0]  hc;

	always_comb begin
		nr = clamp_image(image_rows_q, MAX_ROWS);
		nc = clamp_image(image_cols_q, MAX_COLS);
		kr = clamp_kernel(kernel_rows_q);
		kc = clamp_kernel(kernel_cols_q);
		hr = kr >> 1;
		hc = kc >> 1;
	end

	// Handshake decode.
	cvw_state_t state_q;
	cvw_state_t state_d;

	logic item_acc;
	logic is_compute;
	logic is_load_pixel;
	logic is_load_coef;
	logic out_free;

	assign item_acc      = item.valid & item.ready;
	assign is_compute    = (item.opcode == OP_COMPUTE);
	assign is_load_pixel = (item.opcode == OP_LOAD_PIXEL);
	assign is_load_coef  = (item.opcode == OP_LOAD_COEF);

	// Sequencer registers.
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [POS_W-1:0]     div_row_q;
	logic [POS_W-1:0]     div_col_q;
	logic [CRD_W-1:0]     cur_r_q;
	logic [CRD_W-1:0]     cur_c_q;
	logic [CRD_W-1:0]     col0_q;
	logic [KI_W-1:0]      off_r_q;
	logic [KI_W-1:0]      off_c_q;
	logic [KI_W-1:0]      ki_q;
	logic [KI_W-1:0]      kj_q;
	logic [POS_W-1:0]     req_row_q;
	logic [POS_W-1:0]     req_col_q;

	logic       out_valid_q;
	logic [POS_W-1:0]         out_row_q;
	logic [POS_W-1:0]         out_col_q;
	logic signed [RESP_W-1:0] out_resp_q;

	logic                     mac_done;
	logic signed [RESP_W-1:0] mac_acc;

	assign out_free = !out_valid_q || result.ready;

	logic tap_last;
	logic row_end;
	logic offset_done;

	assign row_end     = (kj_q == kc - KI_W'(1));
	assign tap_last    = row_end && (ki_q == kr - KI_W'(1));
	assign offset_done = (off_r_q == '0) && (off_c_q == '0);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item.valid && is_compute) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_cnt_q == DIV_LAST) begin
					state_d = ST_OFFSET;
				end
			end
			ST_OFFSET: begin
				if (offset_done) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (tap_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (mac_done) begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State outputs.
	logic     item_ready;
	logic     tap_issue;
	logic     out_load;
	cvw_tap_t tap_d;

	always_comb begin
		item_ready = 1'b0;
		tap_issue  = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			ST_IDLE: item_ready = 1'b1;
			ST_WALK: tap_issue  = 1'b1;
			ST_HOLD: out_load   = out_free;
			default: begin
			end
		endcase
		tap_d.valid = tap_issue;
		tap_d.last  = tap_issue & tap_last;
	end

	assign item.ready = item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Remainder step: shift in one dividend bit and subtract the size if it fits.
	logic [CRD_W:0] div_tr;
	logic [CRD_W:0] div_tc;
	logic [CRD_W-1:0] div_nr;
	logic [CRD_W-1:0] div_nc;

	always_comb begin
		div_tr = {cur_r_q, div_row_q[POS_W-1]};
		div_tc = {cur_c_q, div_col_q[POS_W-1]};
		div_nr = (div_tr >= {1'b0, nr}) ? CRD_W'(div_tr - {1'b0, nr}) : CRD_W'(div_tr);
		div_nc = (div_tc >= {1'b0, nc}) ? CRD_W'(div_tc - {1'b0, nc}) : CRD_W'(div_tc);
	end

	// Single steps around the image with wraparound.
	function automatic logic [CRD_W-1:0] wrap_dec(input logic [CRD_W-1:0] v,
	                                              input logic [CRD_W-1:0] n);
		return (v == '0) ? (n - CRD_W'(1)) : (v - CRD_W'(1));
	endfunction

	function automatic logic [CRD_W-1:0] wrap_inc(input logic [CRD_W-1:0] v,
	                                              input logic [CRD_W-1:0] n);
		logic [CRD_W:0] s;
		s = {1'b0, v} + (CRD_W + 1)'(1);
		return (s == {1'b0, n}) ? '0 : CRD_W'(s);
	endfunction

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (item_acc && is_compute) begin
					req_row_q <= item.row;
					req_col_q <= item.col;
					div_row_q <= item.row;
					div_col_q <= item.col;
					div_cnt_q <= '0;
					cur_r_q   <= '0;
					cur_c_q   <= '0;
					ki_q      <= '0;
					kj_q      <= '0;
				end
			end
			ST_DIV: begin
				cur_r_q   <= div_nr;
				cur_c_q   <= div_nc;
				div_row_q <= div_row_q << 1;
				div_col_q <= div_col_q << 1;
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
				off_r_q   <= hr;
				off_c_q   <= hc;
			end
			ST_OFFSET: begin
				if (off_r_q != '0) begin
					cur_r_q <= wrap_dec(cur_r_q, nr);
					off_r_q <= off_r_q - KI_W'(1);
				end
				if (off_c_q != '0) begin
					cur_c_q <= wrap_dec(cur_c_q, nc);
					off_c_q <= off_c_q - KI_W'(1);
				end
				col0_q <= cur_c_q;
			end
			ST_WALK: begin
				if (row_end) begin
					kj_q    <= '0;
					ki_q    <= ki_q + KI_W'(1);
					cur_c_q <= col0_q;
					cur_r_q <= wrap_inc(cur_r_q, nr);
				end else begin
					kj_q    <= kj_q + KI_W'(1);
					cur_c_q <= wrap_inc(cur_c_q, nc);
				end
			end
			default: begin
			end
		endcase
	end

	// Pixel memory: written by pixel load items, read once per kernel tap.
	logic [PIX_W-1:0] pix_mem [PIX_DEPTH];
	logic [PIX_W-1:0] pix_rd_s1;
	logic [PA_W-1:0]  pix_waddr;
	logic [PA_W-1:0]  pix_raddr;
	logic             pix_wen;

	assign pix_wen = item_acc && is_load_pixel
		&& (CMP_W'(item.row) < CMP_W'(MAX_ROWS))
		&& (CMP_W'(item.col) < CMP_W'(MAX_COLS));
	assign pix_waddr = PA_W'(MUL_W'(item.row) * MUL_W'(MAX_COLS) + MUL_W'(item.col));
	assign pix_raddr = PA_W'(MUL_W'(cur_r_q) * MUL_W'(MAX_COLS) + MUL_W'(cur_c_q));

	always_ff @(posedge clk) begin
		if (pix_wen) begin
			pix_mem[pix_waddr] <= item.pixel;
		end
		pix_rd_s1 <= pix_mem[pix_raddr];
	end

	// Kernel memory: written by coefficient loads, read once per kernel tap.
	logic signed [COEF_W-1:0] ker_mem [KER_DEPTH];
	logic signed [COEF_W-1:0] coef_rd_s1;
	logic [KA_W-1:0]          ker_waddr;
	logic [KA_W-1:0]          ker_raddr;
	logic                     ker_wen;

	assign ker_wen = item_acc && is_load_coef
		&& (item.row < POS_W'(MAX_KERNEL))
		&& (item.col < POS_W'(MAX_KERNEL));
	assign ker_waddr = KA_W'(POS_W'(item.row) * POS_W'(MAX_KERNEL) + POS_W'(item.col));
	assign ker_raddr = KA_W'(POS_W'(ki_q) * POS_W'(MAX_KERNEL) + POS_W'(kj_q));

	always_ff @(posedge clk) begin
		if (ker_wen) begin
			ker_mem[ker_waddr] <= item.coefficient;
		end
		coef_rd_s1 <= ker_mem[ker_raddr];
	end

	// The tap tag lines up with the registered memory read data.
	cvw_tap_t tap_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_s1 <= '0;
		end else begin
			tap_s1 <= tap_d;
		end
	end

	cvw_mac u_mac (
		.clk         (clk),
		.arst_n      (arst_n),
		.clear       (item_acc && is_compute),
		.tap         (tap_s1),
		.pixel       (pix_rd_s1),
		.coefficient (coef_rd_s1),
		.acc         (mac_acc),
		.done        (mac_done)
	);

	// Output register: holds one finished result until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_row_q  <= req_row_q;
			out_col_q  <= req_col_q;
			out_resp_q <= mac_acc;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.out_row  = out_row_q;
	assign result.out_col  = out_col_q;
	assign result.response = out_resp_q;

endmodule

`default_nettype wire
